/* rtl/gcsw_pkg.sv */
// ----------------------------------------------------------------------------
// gcsw_pkg
// Types, constants and helpers shared by the sliding window gc content block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcsw_pkg;

   localparam int CFG_W      = 13;
   localparam int BASE_W     = 8;
   localparam int POS_W      = 32;
   localparam int PCT_W      = 15;
   localparam int PROD_W     = CFG_W + PCT_W;
   localparam int DIV_STEPS  = PCT_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int WINDOW_MAX_DEFAULT = 4096;

   localparam logic [PCT_W-1:0]  PCT_SCALE          = PCT_W'(25600);
   localparam logic [CFG_W-1:0]  WINDOW_LENGTH_INIT = CFG_W'(1024);
   localparam logic [CFG_W-1:0]  STEP_LENGTH_INIT   = CFG_W'(1);

   localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
   localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
   localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
   localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

   typedef enum logic {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_STEP_LENGTH   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic unknown;
      logic gc;
   } base_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_START,
      ST_DIVIDE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic update;
      logic div_start;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic emit;
      logic div_done;
   } dp_status_type;

   function automatic base_flags_type classify(input logic [BASE_W-1:0] code);
      base_flags_type f;
      f.gc      = (code == CHAR_G) || (code == CHAR_C);
      f.unknown = !((code == CHAR_G) || (code == CHAR_C) ||
                    (code == CHAR_A) || (code == CHAR_T));
      return f;
   endfunction

endpackage

/* rtl/gcsw_div.sv */
// ----------------------------------------------------------------------------
// gcsw_div
// Restoring divider for the gc percentage, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcsw_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gcsw_pkg::CFG_W-1:0]  gc_value,
   input  logic [gcsw_pkg::CFG_W-1:0]  divisor,
   output logic                        done,
   output logic [gcsw_pkg::PCT_W-1:0]  quotient
);
   import gcsw_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [CFG_W-1:0]     rem_ff, rem_in;
   logic [PCT_W-1:0]     low_ff, low_in;
   logic [CFG_W-1:0]     div_ff, div_in;
   logic                 zero_ff, zero_in;
   logic [PROD_W-1:0]    product;
   logic [CFG_W+1:0]     trial;

   assign product = PROD_W'(gc_value) * PROD_W'(PCT_SCALE);
   assign trial   = {1'b0, rem_ff, low_ff[PCT_W-1]} - {2'b00, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      div_in  = div_ff;
      zero_in = zero_ff;
      if (start) begin
         // quotient stays below 2^15, so the top bits already sit under the divisor
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_STEPS);
         rem_in  = product[PROD_W-1:PCT_W];
         low_in  = product[PCT_W-1:0];
         div_in  = divisor;
         zero_in = (divisor == '0);
      end else if (busy_ff) begin
         if (!trial[CFG_W+1]) begin
            rem_in = trial[CFG_W-1:0];
            low_in = {low_ff[PCT_W-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[CFG_W-2:0], low_ff[PCT_W-1]};
            low_in = {low_ff[PCT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      div_ff  <= div_in;
      zero_ff <= zero_in;
   end

   assign done     = !busy_ff;
   assign quotient = zero_ff ? '0 : low_ff;

endmodule

/* rtl/gcsw_dp.sv */
// ----------------------------------------------------------------------------
// gcsw_dp
// Flag ring, running counts, positions, emission counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcsw_dp #(
   parameter int WINDOW_MAX = gcsw_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gcsw_pkg::dp_cmd_type         cmd,
   output logic                         emit,
   input  logic [gcsw_pkg::BASE_W-1:0]  base_code,
   input  logic                         restart,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [gcsw_pkg::CFG_W-1:0]   csr_write_data,
   output logic [gcsw_pkg::CFG_W-1:0]   div_gc,
   output logic [gcsw_pkg::CFG_W-1:0]   div_known,
   input  logic [gcsw_pkg::PCT_W-1:0]   div_quotient,
   output logic [gcsw_pkg::POS_W-1:0]   window_start,
   output logic [gcsw_pkg::POS_W-1:0]   window_end,
   output logic [gcsw_pkg::CFG_W-1:0]   gc_bases,
   output logic [gcsw_pkg::CFG_W-1:0]   known_bases,
   output logic [gcsw_pkg::PCT_W-1:0]   gc_percent_q8
);
   import gcsw_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_MAX);

   base_flags_type   flag_ring_ff [WINDOW_MAX];
   base_flags_type   old_flags_ff;
   base_flags_type   flags_ff;
   logic [IDX_W-1:0] idx_ff;

   logic [CFG_W-1:0] window_length_ff, window_length_in;
   logic [CFG_W-1:0] step_length_ff, step_length_in;
   logic [IDX_W-1:0] ring_index_ff, ring_index_in;
   logic [CFG_W-1:0] gc_ff, gc_in;
   logic [CFG_W-1:0] unknown_ff, unknown_in;
   logic [POS_W-1:0] bases_seen_ff, bases_seen_in;
   logic [CFG_W-1:0] until_ff, until_in;

   logic [POS_W-1:0] start_ff;
   logic [POS_W-1:0] end_ff;
   logic [CFG_W-1:0] gc_out_ff;
   logic [CFG_W-1:0] known_out_ff;
   logic [PCT_W-1:0] pct_out_ff;

   logic [CFG_W-1:0] win_eff;
   logic [CFG_W-1:0] step_eff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] idx_next;
   logic [POS_W-1:0] seen_next;
   logic             full_now;
   logic             full_next;
   logic             gc_drop;
   logic             unknown_drop;
   logic [CFG_W-1:0] known;

   always_comb begin
      if (window_length_ff == '0) begin
         win_eff = CFG_W'(1);
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         win_eff = CFG_W'(WINDOW_MAX);
      end else begin
         win_eff = window_length_ff;
      end
      if (step_length_ff == '0) begin
         step_eff = CFG_W'(1);
      end else if (step_length_ff > win_eff) begin
         step_eff = win_eff;
      end else begin
         step_eff = step_length_ff;
      end
   end

   assign rd_addr = (restart || (32'(ring_index_ff) >= 32'(win_eff))) ? '0 : ring_index_ff;
   assign idx_next = ((32'(idx_ff) + 32'd1) >= 32'(win_eff)) ? '0 : idx_ff + IDX_W'(1);
   assign seen_next = (bases_seen_ff != '1) ? bases_seen_ff + POS_W'(1) : bases_seen_ff;
   assign full_now  = bases_seen_ff >= POS_W'(win_eff);
   assign full_next = seen_next >= POS_W'(win_eff);
   assign gc_drop      = full_now && old_flags_ff.gc && (gc_ff != '0);
   assign unknown_drop = full_now && old_flags_ff.unknown && (unknown_ff != '0);
   assign known = (unknown_ff <= win_eff) ? win_eff - unknown_ff : '0;
   assign emit  = full_next && (until_ff == '0);

   always_comb begin
      window_length_in = window_length_ff;
      step_length_in   = step_length_ff;
      ring_index_in    = ring_index_ff;
      gc_in            = gc_ff;
      unknown_in       = unknown_ff;
      bases_seen_in    = bases_seen_ff;
      until_in         = until_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH: window_length_in = csr_write_data;
            CSR_STEP_LENGTH:   step_length_in   = csr_write_data;
            default:           window_length_in = window_length_ff;
         endcase
         ring_index_in = '0;
         gc_in         = '0;
         unknown_in    = '0;
         bases_seen_in = '0;
         until_in      = '0;
      end else if (cmd.accept && restart) begin
         ring_index_in = '0;
         gc_in         = '0;
         unknown_in    = '0;
         bases_seen_in = '0;
         until_in      = '0;
      end else if (cmd.update) begin
         gc_in = gc_ff - CFG_W'(gc_drop) + CFG_W'(flags_ff.gc);
         unknown_in = unknown_ff - CFG_W'(unknown_drop) + CFG_W'(flags_ff.unknown);
         ring_index_in = idx_next;
         bases_seen_in = seen_next;
         if (full_next) begin
            until_in = (until_ff != '0) ? until_ff - CFG_W'(1) : step_eff - CFG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_INIT;
         step_length_ff   <= STEP_LENGTH_INIT;
         ring_index_ff    <= '0;
         gc_ff            <= '0;
         unknown_ff       <= '0;
         bases_seen_ff    <= '0;
         until_ff         <= '0;
      end else begin
         window_length_ff <= window_length_in;
         step_length_ff   <= step_length_in;
         ring_index_ff    <= ring_index_in;
         gc_ff            <= gc_in;
         unknown_ff       <= unknown_in;
         bases_seen_ff    <= bases_seen_in;
         until_ff         <= until_in;
      end
   end

   // flag ring, read in the cycle before the write back
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         flag_ring_ff[idx_ff] <= flags_ff;
      end
      old_flags_ff <= flag_ring_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         flags_ff <= classify(base_code);
         idx_ff   <= rd_addr;
      end
      if (cmd.load_out) begin
         start_ff     <= bases_seen_ff - POS_W'(win_eff);
         end_ff       <= bases_seen_ff;
         gc_out_ff    <= gc_ff;
         known_out_ff <= known;
         pct_out_ff   <= div_quotient;
      end
   end

   assign div_gc        = gc_ff;
   assign div_known     = known;
   assign window_start  = start_ff;
   assign window_end    = end_ff;
   assign gc_bases      = gc_out_ff;
   assign known_bases   = known_out_ff;
   assign gc_percent_q8 = pct_out_ff;

endmodule

/* rtl/gcsw_ctrl.sv */
// ----------------------------------------------------------------------------
// gcsw_ctrl
// Sequencer for accept, ring update, division and result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcsw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output gcsw_pkg::dp_cmd_type     cmd,
   input  gcsw_pkg::dp_status_type  status
);
   import gcsw_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.emit ? ST_START : ST_IDLE;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // previous result must have gone before the register is reloaded
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/gc_sliding_window_percent.sv */
// ----------------------------------------------------------------------------
// gc_sliding_window_percent
// A result is loaded after the closing base passes accept, update, start,
// divide and output. A new base is taken only when idle, after the ring
// read-modify-write and, if it emits, the 15-step bit-serial divider.
// Synchronous reset restores window 1024 and step 1 and clears the counts;
// the flag ring needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gc_sliding_window_percent #(
   parameter int WINDOW_MAX = gcsw_pkg::WINDOW_MAX_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gcsw_pkg::BASE_W-1:0]  req_base_code,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gcsw_pkg::POS_W-1:0]   rsp_window_start,
   output logic [gcsw_pkg::POS_W-1:0]   rsp_window_end,
   output logic [gcsw_pkg::CFG_W-1:0]   rsp_gc_bases,
   output logic [gcsw_pkg::CFG_W-1:0]   rsp_known_bases,
   output logic [gcsw_pkg::PCT_W-1:0]   rsp_gc_percent_q8,
   input  logic                         csr_write_enable,
   input  logic                         csr_index,
   input  logic [gcsw_pkg::CFG_W-1:0]   csr_write_data
);
   import gcsw_pkg::*;

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic             emit;
   logic             div_done;
   logic [CFG_W-1:0] div_gc;
   logic [CFG_W-1:0] div_known;
   logic [PCT_W-1:0] div_quotient;

   assign status.emit     = emit;
   assign status.div_done = div_done;

   gcsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   gcsw_dp #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .emit             (emit),
      .base_code        (req_base_code),
      .restart          (req_restart),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .div_gc           (div_gc),
      .div_known        (div_known),
      .div_quotient     (div_quotient),
      .window_start     (rsp_window_start),
      .window_end       (rsp_window_end),
      .gc_bases         (rsp_gc_bases),
      .known_bases      (rsp_known_bases),
      .gc_percent_q8    (rsp_gc_percent_q8)
   );

   gcsw_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .gc_value (div_gc),
      .divisor  (div_known),
      .done     (div_done),
      .quotient (div_quotient)
   );

endmodule

/* tb/sv/tb_gc_sliding_window_percent.sv */
// ----------------------------------------------------------------------------
// tb_gc_sliding_window_percent
// Streams base characters through the sliding window gc content block and
// checks every emitted window against a cycle-free model of the window
// counts, over directed cases, clamped and extreme register settings and
// random sequences with random gaps and result back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_gc_sliding_window_percent;

   import gcsw_pkg::*;

   localparam int WINDOW_SLOTS   = WINDOW_MAX_DEFAULT;
   localparam int DRAIN_CYCLES   = 30;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [POS_W-1:0] window_start;
      logic [POS_W-1:0] window_end;
      logic [CFG_W-1:0] gc_bases;
      logic [CFG_W-1:0] known_bases;
      logic [PCT_W-1:0] gc_percent_q8;
   } window_result_t;

   class gc_content_scoreboard;
      window_result_t pending_windows[$];
      int unsigned    mismatches;
      logic [CFG_W-1:0] window_reg;
      logic [CFG_W-1:0] stride_reg;
      base_flags_type flag_ring [WINDOW_SLOTS];
      int unsigned    ring_pos;
      int unsigned    gc_total;
      int unsigned    unknown_count;
      int unsigned    position;
      int unsigned    emit_countdown;

      function new();
         window_reg = WINDOW_LENGTH_INIT;
         stride_reg = STEP_LENGTH_INIT;
         mismatches = 0;
         clear_counts();
      endfunction

      function void clear_counts();
         ring_pos       = 0;
         gc_total       = 0;
         unknown_count  = 0;
         position       = 0;
         emit_countdown = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CFG_W-1:0] data);
         case (idx)
            CSR_WINDOW_LENGTH: window_reg = data;
            CSR_STEP_LENGTH:   stride_reg = data;
         endcase
         clear_counts();
      endfunction

      // one accepted base: update the ring and counts, queue a window if due
      function void take_base(logic [BASE_W-1:0] code, logic restart);
         int unsigned    win;
         int unsigned    stride;
         int unsigned    slot;
         int unsigned    known;
         base_flags_type flags;
         window_result_t want;
         win = window_reg;
         if (win == 0) win = 1;
         if (win > WINDOW_SLOTS) win = WINDOW_SLOTS;
         stride = stride_reg;
         if (stride == 0) stride = 1;
         if (stride > win) stride = win;
         flags.gc      = (code == CHAR_G) || (code == CHAR_C);
         flags.unknown = !(flags.gc || code == CHAR_A || code == CHAR_T);
         if (restart) clear_counts();
         if (ring_pos >= win) ring_pos = 0;
         slot = ring_pos;
         if (position >= win) begin
            if (flag_ring[slot].gc && gc_total > 0) gc_total--;
            if (flag_ring[slot].unknown && unknown_count > 0) unknown_count--;
         end
         flag_ring[slot] = flags;
         gc_total      += flags.gc;
         unknown_count += flags.unknown;
         ring_pos = (slot + 1 >= win) ? 0 : slot + 1;
         if (position != 32'hFFFF_FFFF) position++;
         if (position < win) return;
         if (emit_countdown != 0) begin
            emit_countdown--;
            return;
         end
         emit_countdown     = stride - 1;
         known              = (unknown_count <= win) ? win - unknown_count : 0;
         want.window_start  = position - win;
         want.window_end    = position;
         want.gc_bases      = gc_total[CFG_W-1:0];
         want.known_bases   = known[CFG_W-1:0];
         want.gc_percent_q8 = '0;
         if (known != 0) begin
            want.gc_percent_q8 = PCT_W'((64'(gc_total) * 64'd25600) / 64'(known));
         end
         pending_windows.insert(pending_windows.size(), want);
      endfunction

      function void check_window(window_result_t got);
         window_result_t want;
         if (pending_windows.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected window: start %0d end %0d gc %0d known %0d pct %0d",
                        got.window_start, got.window_end, got.gc_bases,
                        got.known_bases, got.gc_percent_q8);
            end
            return;
         end
         want = pending_windows.pop_front();
         if (got.window_start !== want.window_start || got.window_end !== want.window_end ||
             got.gc_bases !== want.gc_bases || got.known_bases !== want.known_bases ||
             got.gc_percent_q8 !== want.gc_percent_q8) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("window mismatch: expected start %0d end %0d gc %0d known %0d pct %0d",
                        want.window_start, want.window_end, want.gc_bases,
                        want.known_bases, want.gc_percent_q8);
               $display("                 got      start %0d end %0d gc %0d known %0d pct %0d",
                        got.window_start, got.window_end, got.gc_bases,
                        got.known_bases, got.gc_percent_q8);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [BASE_W-1:0]  req_base_code = '0;
   logic               req_restart = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [POS_W-1:0]   rsp_window_start;
   logic [POS_W-1:0]   rsp_window_end;
   logic [CFG_W-1:0]   rsp_gc_bases;
   logic [CFG_W-1:0]   rsp_known_bases;
   logic [PCT_W-1:0]   rsp_gc_percent_q8;
   logic               csr_write_enable = 1'b0;
   logic               csr_index = 1'b0;
   logic [CFG_W-1:0]   csr_write_data = '0;

   window_result_t       rsp_window;
   gc_content_scoreboard board;
   int unsigned          quiet_cycles = 0;
   int unsigned          stall_left = 0;
   int unsigned          free_left = 0;
   int unsigned          req_gap_pct = 0;
   int unsigned          gc_weight = 2;
   int unsigned          random_items = 0;
   logic                 no_idling = 1'b0;

   gc_sliding_window_percent i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_base_code     (req_base_code),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window_start  (rsp_window_start),
      .rsp_window_end    (rsp_window_end),
      .rsp_gc_bases      (rsp_gc_bases),
      .rsp_known_bases   (rsp_known_bases),
      .rsp_gc_percent_q8 (rsp_gc_percent_q8),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   assign rsp_window = {rsp_window_start, rsp_window_end, rsp_gc_bases,
                        rsp_known_bases, rsp_gc_percent_q8};

   initial begin
      forever #6 clock = ~clock;
   end

   // transfers, register writes and the watchdog, all seen at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_window(rsp_window);
         if (req_valid && !req_stall) board.take_base(req_base_code, req_restart);
         if (csr_write_enable) board.write_register(csr_index_type'(csr_index), csr_write_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("DONE: errors detected");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // result back-pressure in bursts, with free stretches in between
   always @(negedge clock) begin
      if (no_idling || reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (free_left != 0) begin
         free_left <= free_left - 1;
         rsp_stall <= 1'b0;
      end else if ($urandom_range(0, 1) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall  <= 1'b1;
      end else begin
         free_left <= $urandom_range(0, 60);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [BASE_W-1:0] pick_base();
      case ($urandom_range(0, 19))
         0, 1: return BASE_W'($urandom_range(0, 255));
         2: return "N";
         3: begin
            case ($urandom_range(0, 3))
               0: return "a";
               1: return "c";
               2: return "g";
               default: return "t";
            endcase
         end
         default: begin
            if ($urandom_range(0, 3) < gc_weight) begin
               return ($urandom_range(0, 1) != 0) ? CHAR_G : CHAR_C;
            end
            return ($urandom_range(0, 1) != 0) ? CHAR_A : CHAR_T;
         end
      endcase
   endfunction

   task automatic send_base(input logic [BASE_W-1:0] code, input logic restart);
      if (!no_idling && req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_base_code = code;
      req_restart   = restart;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CFG_W-1:0] data);
      req_valid = 1'b0;
      while (board.pending_windows.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   task automatic configure(input int unsigned win, input int unsigned stride);
      write_csr(CSR_WINDOW_LENGTH, CFG_W'(win));
      write_csr(CSR_STEP_LENGTH, CFG_W'(stride));
   endtask

   task automatic run_bases(input int unsigned count);
      for (int unsigned i = 0; i < count; i++) begin
         send_base(pick_base(), $urandom_range(0, 49) == 0);
      end
   endtask

   initial begin
      int unsigned win;
      int unsigned stride;
      int unsigned count;
      board = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values of the registers
      req_gap_pct = 20;
      run_bases(1030);

      // directed: mixed, lowercase, all unknown, all gc, restart mid window
      req_gap_pct = 0;
      configure(4, 1);
      send_base(CHAR_A, 1'b0);
      send_base(CHAR_C, 1'b0);
      send_base(CHAR_G, 1'b0);
      send_base(CHAR_T, 1'b0);
      send_base("g", 1'b0);
      send_base("N", 1'b0);
      send_base(8'h00, 1'b0);
      send_base(8'hFF, 1'b0);
      send_base(CHAR_G, 1'b0);
      send_base(CHAR_C, 1'b0);
      send_base(CHAR_G, 1'b0);
      send_base(CHAR_C, 1'b0);
      send_base(CHAR_A, 1'b1);
      send_base(CHAR_T, 1'b0);
      send_base(CHAR_A, 1'b0);
      send_base(CHAR_T, 1'b0);
      // zero window and zero step both act as one
      configure(0, 0);
      send_base(CHAR_G, 1'b0);
      send_base("a", 1'b0);
      send_base(CHAR_C, 1'b1);
      // step beyond the window is clamped
      configure(3, 8191);
      send_base(8'h80, 1'b0);
      send_base(8'h7F, 1'b0);
      send_base("c", 1'b0);
      send_base(CHAR_G, 1'b0);
      send_base(CHAR_A, 1'b0);
      send_base(CHAR_T, 1'b0);

      // random settings, mostly small windows
      while (random_items < 520) begin
         case ($urandom_range(0, 9))
            0: win = 0;
            1: win = $urandom_range(40, 120);
            default: win = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 5))
            0: stride = 0;
            1: stride = 8191;
            2: stride = win;
            default: stride = $urandom_range(1, win + 1);
         endcase
         case ($urandom_range(0, 2))
            0: req_gap_pct = 0;
            1: req_gap_pct = 15;
            default: req_gap_pct = 40;
         endcase
         gc_weight = $urandom_range(0, 4);
         count     = win + $urandom_range(20, 100);
         if (random_items >= 420) no_idling = 1'b1;
         configure(win, stride);
         run_bases(count);
         random_items += count;
      end

      req_valid = 1'b0;
      while (board.pending_windows.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (board.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/gcsw_pkg.sv
rtl/gcsw_div.sv
rtl/gcsw_dp.sv
rtl/gcsw_ctrl.sv
rtl/gc_sliding_window_percent.sv
tb/sv/tb_gc_sliding_window_percent.sv
